FILE: rtl/pla3d_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pla3d_pkg
// Shared types and defaults for the 3D path length accumulator.
// ----------------------------------------------------------------------------
package pla3d_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 8;
  localparam int unsigned TOTAL_BITS_DEF = 40;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_ADD,
    ST_ROOT,
    ST_ACC,
    ST_DONE
  } pla3d_state_e;

  typedef enum logic [1:0] {
    SQ_X,
    SQ_Y,
    SQ_Z
  } pla3d_sq_sel_e;

  typedef struct packed {
    logic          load;       // capture waypoint, form deltas
    logic          mul_en;     // square one delta
    pla3d_sq_sel_e mul_sel;
    logic          add_en;     // add product into sum of squares
    logic          root_load;  // start square root
    logic          root_step;  // one root bit
    logic          acc_en;     // add segment into total
    logic          emit;       // load result register, clear total
  } pla3d_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/pla3d_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pla3d_in_if
// Waypoint channel: valid/ready with coordinates and last-point flag.
// ----------------------------------------------------------------------------
interface pla3d_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic signed [COORD_BITS-1:0] height;
  logic                         last_point;

  modport source (output valid, x_coord, y_coord, height, last_point, input ready);
  modport sink   (input valid, x_coord, y_coord, height, last_point, output ready);
endinterface
`default_nettype wire

FILE: rtl/pla3d_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pla3d_out_if
// Result channel: valid/ready with path length and saturation flag.
// ----------------------------------------------------------------------------
interface pla3d_out_if #(
  parameter int unsigned TOTAL_BITS = 40
);
  logic                  valid;
  logic                  ready;
  logic [TOTAL_BITS-1:0] total_distance;
  logic                  overflowed;

  modport source (output valid, total_distance, overflowed, input ready);
  modport sink   (input valid, total_distance, overflowed, output ready);
endinterface
`default_nettype wire

FILE: rtl/pla3d_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pla3d_ctrl
// Sequencer: squares, square root steps, accumulation and result hand-off.
// ----------------------------------------------------------------------------
module pla3d_ctrl
  import pla3d_pkg::*;
#(
  parameter int unsigned ROOT_BITS = COORD_BITS_DEF + FRAC_BITS_DEF + 1
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic in_last_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output pla3d_cmd_t cmd_o
);

  localparam int unsigned CNT_BITS = $clog2(ROOT_BITS);

  pla3d_state_e        state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                have_prev_q, have_prev_d;
  logic                last_q, last_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      have_prev_q <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      have_prev_q <= have_prev_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    have_prev_d = have_prev_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.mul_sel = SQ_X;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          last_d     = in_last_i;
          state_d    = have_prev_q ? ST_SQ0 : ST_DONE;
        end
      end
      ST_SQ0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = SQ_X;
        state_d       = ST_SQ1;
      end
      ST_SQ1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = SQ_Y;
        cmd_o.add_en  = 1'b1;
        state_d       = ST_SQ2;
      end
      ST_SQ2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = SQ_Z;
        cmd_o.add_en  = 1'b1;
        state_d       = ST_ADD;
      end
      ST_ADD: begin
        // last product goes straight into the root radicand
        cmd_o.root_load = 1'b1;
        cnt_d           = '0;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == CNT_BITS'(ROOT_BITS - 1)) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (last_q) begin
          // hold until the previous result has been taken
          if (!out_valid_q || out_ready_i) begin
            cmd_o.emit  = 1'b1;
            out_valid_d = 1'b1;
            have_prev_d = 1'b0;
            state_d     = ST_IDLE;
          end
        end else begin
          have_prev_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/pla3d_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pla3d_dp
// Datapath: deltas, shared squarer, bit-serial square root, saturating total.
// ----------------------------------------------------------------------------
module pla3d_dp
  import pla3d_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned TOTAL_BITS = TOTAL_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pla3d_cmd_t                   cmd_i,
  input  wire logic signed [COORD_BITS-1:0] x_coord_i,
  input  wire logic signed [COORD_BITS-1:0] y_coord_i,
  input  wire logic signed [COORD_BITS-1:0] height_i,
  output logic [TOTAL_BITS-1:0]             total_distance_o,
  output logic                              overflowed_o
);

  localparam int unsigned SUM_BITS  = 2 * COORD_BITS + 2;
  localparam int unsigned ROOT_BITS = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned RAD_BITS  = 2 * ROOT_BITS;
  localparam int unsigned REM_BITS  = ROOT_BITS + 2;
  localparam int unsigned ACC_BITS  =
    ((TOTAL_BITS > ROOT_BITS) ? TOTAL_BITS : ROOT_BITS) + 1;
  localparam logic [ACC_BITS-1:0] TOTAL_MAX = ACC_BITS'({TOTAL_BITS{1'b1}});

  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic [COORD_BITS-1:0] a,
    input logic [COORD_BITS-1:0] b
  );
    logic [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    if (d[COORD_BITS]) begin
      d = -d;
    end
    return d[COORD_BITS-1:0];
  endfunction

  logic [COORD_BITS-1:0]   prev_x_q, prev_y_q, prev_h_q;
  logic [COORD_BITS-1:0]   dx_q, dy_q, dz_q;
  logic [COORD_BITS-1:0]   mul_op;
  logic [2*COORD_BITS-1:0] prod_q;
  logic [SUM_BITS-1:0]     sum_q, sum_next;
  logic [RAD_BITS-1:0]     rad_q;
  logic [REM_BITS-1:0]     rem_q, rem_sh, trial;
  logic [ROOT_BITS-1:0]    root_q;
  logic                    root_ge;
  logic [ACC_BITS-1:0]     acc_sum;
  logic [TOTAL_BITS-1:0]   total_q;
  logic                    sat_q;
  logic [TOTAL_BITS-1:0]   out_total_q;
  logic                    out_ovf_q;

  always_comb begin
    case (cmd_i.mul_sel)
      SQ_X:    mul_op = dx_q;
      SQ_Y:    mul_op = dy_q;
      SQ_Z:    mul_op = dz_q;
      default: mul_op = dx_q;
    endcase
  end

  assign sum_next = sum_q + SUM_BITS'(prod_q);

  // one radicand digit pair per step
  assign rem_sh  = {rem_q[ROOT_BITS-1:0], rad_q[RAD_BITS-1 -: 2]};
  assign trial   = {root_q[ROOT_BITS-1:0], 2'b01};
  assign root_ge = (rem_sh >= trial);

  assign acc_sum = ACC_BITS'(total_q) + ACC_BITS'(root_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q     <= abs_diff(x_coord_i, prev_x_q);
      dy_q     <= abs_diff(y_coord_i, prev_y_q);
      dz_q     <= abs_diff(height_i, prev_h_q);
      prev_x_q <= x_coord_i;
      prev_y_q <= y_coord_i;
      prev_h_q <= height_i;
      sum_q    <= '0;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_op * mul_op;
    end
    if (cmd_i.add_en) begin
      sum_q <= sum_next;
    end
    if (cmd_i.root_load) begin
      rad_q  <= RAD_BITS'(sum_next) << (2 * FRAC_BITS);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.root_step) begin
      rad_q  <= rad_q << 2;
      rem_q  <= root_ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[ROOT_BITS-2:0], root_ge};
    end
    if (cmd_i.emit) begin
      out_total_q <= total_q;
      out_ovf_q   <= sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      sat_q   <= 1'b0;
    end else if (cmd_i.emit) begin
      total_q <= '0;
      sat_q   <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (acc_sum > TOTAL_MAX) begin
        total_q <= {TOTAL_BITS{1'b1}};
        sat_q   <= 1'b1;
      end else begin
        total_q <= acc_sum[TOTAL_BITS-1:0];
      end
    end
  end

  assign total_distance_o = out_total_q;
  assign overflowed_o     = out_ovf_q;

endmodule
`default_nettype wire

FILE: rtl/path_length_accumulator_3d_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// path_length_accumulator_3d_core
// Sums the 3D Euclidean length of a polyline fed one waypoint per item.
// ----------------------------------------------------------------------------
// Each waypoint after the first of a path adds sqrt(dx^2 + dy^2 + dz^2),
// truncated to FRAC_BITS fractional bits, to a saturating total; the item
// with last_point set releases the total and overflow flag as one result
// and starts a new path. The first waypoint of a path adds no length; for
// every later one the time is set by the bit-serial square root, which
// yields one root bit per cycle, plus three passes through the single
// shared squarer. A finished result sits in its own register, so the next
// waypoint is taken while it waits; only a further last waypoint stalls
// until that result has been taken.
// ----------------------------------------------------------------------------
module path_length_accumulator_3d_core
  import pla3d_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned TOTAL_BITS = TOTAL_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pla3d_in_if.sink   wp_i,
  pla3d_out_if.source res_o
);

  localparam int unsigned ROOT_BITS = COORD_BITS + FRAC_BITS + 1;

  pla3d_cmd_t cmd;

  pla3d_ctrl #(
    .ROOT_BITS (ROOT_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (wp_i.valid),
    .in_ready_o  (wp_i.ready),
    .in_last_i   (wp_i.last_point),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd)
  );

  pla3d_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .x_coord_i        (wp_i.x_coord),
    .y_coord_i        (wp_i.y_coord),
    .height_i         (wp_i.height),
    .total_distance_o (res_o.total_distance),
    .overflowed_o     (res_o.overflowed)
  );

endmodule
`default_nettype wire
